>>> design/pip_pkg.sv
// shared types, constants and helpers for the point-in-quadrilateral block
`timescale 1ns / 1ps

package pip_pkg;

    localparam int COORD_WIDTH    = 24;
    localparam int NUM_VERTS      = 4;
    localparam int NUM_REGS       = 2 * NUM_VERTS;
    localparam int REG_IDX_WIDTH  = $clog2(NUM_REGS);
    localparam int EDGE_IDX_WIDTH = $clog2(NUM_VERTS);
    localparam int CNT_WIDTH      = 3;
    localparam int PROD_WIDTH     = 2 * COORD_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [COORD_WIDTH:0]   diff_t;
    typedef logic signed [COORD_WIDTH+1:0] cx_t;
    typedef logic        [COORD_WIDTH-1:0] mag_t;
    typedef logic        [PROD_WIDTH-1:0]  prod_t;
    typedef logic        [CNT_WIDTH-1:0]   cnt_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
    } point_t;

    typedef struct packed {
        logic                 inside_res;
        logic [CNT_WIDTH-1:0] crossings;
    } result_t;

    // one edge on its way through the divider chain
    typedef struct packed {
        logic   active;
        logic   neg;
        coord_t bx;
        mag_t   cmag;
        prod_t  acc;
    } lane_t;

    function automatic diff_t ext_diff(coord_t v);
        return {v[COORD_WIDTH-1], v};
    endfunction

    function automatic cx_t ext_cx(coord_t v);
        return {{2{v[COORD_WIDTH-1]}}, v};
    endfunction

    function automatic mag_t mag_of(diff_t v);
        logic [COORD_WIDTH:0] tmp;
        tmp = v[COORD_WIDTH] ? (~v + 1'b1) : v;
        return tmp[COORD_WIDTH-1:0];
    endfunction

endpackage

>>> design/point_in_quadrilateral.sv
// Point-in-quadrilateral test by ray casting toward +x over the four sides v0-v1, v1-v2,
// v2-v3, v3-v0. One point beat is accepted per cycle unless the output stalls, and one
// result beat leaves for each. The pipeline is two setup stages (differences, then the
// magnitude product), a chain of COORD_WIDTH restoring division cells that each settle
// one quotient bit of all four crossings, and three stages for crossing x, the
// right-of-point and repeat checks, and the count. When m_ready is low with a result
// waiting, the whole pipeline holds and s_ready drops. The user must write the vertex
// registers through cfg_we/cfg_index/cfg_wdata while no point is in flight, unenforced.
`timescale 1ns / 1ps

module point_in_quadrilateral
    import pip_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  point_t                    s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output result_t                   m_data,
    input  logic                      cfg_we,
    input  logic [REG_IDX_WIDTH-1:0]  cfg_index,
    input  coord_t                    cfg_wdata
);

    coord_t [NUM_REGS-1:0]  vertex_reg;
    logic                   en;

    logic                   chain_valid [0:COORD_WIDTH];
    coord_t                 chain_px    [0:COORD_WIDTH];
    lane_t [NUM_VERTS-1:0]  chain_lanes [0:COORD_WIDTH];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_reg <= '0;
        end else if (cfg_we) begin
            vertex_reg[cfg_index] <= cfg_wdata;
        end
    end

    pip_edge_setup u_setup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_point  (s_data),
        .vertex    (vertex_reg),
        .out_valid (chain_valid[0]),
        .out_px    (chain_px[0]),
        .out_lanes (chain_lanes[0])
    );

    genvar k;
    generate
        for (k = 0; k < COORD_WIDTH; k++) begin : g_cell
            pip_div_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (chain_valid[k]),
                .in_px     (chain_px[k]),
                .in_lanes  (chain_lanes[k]),
                .out_valid (chain_valid[k+1]),
                .out_px    (chain_px[k+1]),
                .out_lanes (chain_lanes[k+1])
            );
        end
    endgenerate

    pip_crossing_count u_count (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (chain_valid[COORD_WIDTH]),
        .in_px      (chain_px[COORD_WIDTH]),
        .in_lanes   (chain_lanes[COORD_WIDTH]),
        .out_valid  (m_valid),
        .out_result (m_data)
    );

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.crossings <= CNT_WIDTH'(NUM_VERTS)))
        else $error("crossing count out of range");

    a_inside_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.inside_res == m_data.crossings[0]))
        else $error("inside flag does not match count parity");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while output stalled");
`endif

endmodule

>>> design/pip_edge_setup.sv
// edge setup: differences, skip flags, signs and magnitude products for all edges
`timescale 1ns / 1ps

module pip_edge_setup
    import pip_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  point_t                      in_point,
    input  coord_t [NUM_REGS-1:0]       vertex,
    output logic                        out_valid,
    output coord_t                      out_px,
    output lane_t  [NUM_VERTS-1:0]      out_lanes
);

    logic                    s0_valid_reg;
    coord_t                  s0_px_reg;
    logic   [NUM_VERTS-1:0]  s0_active_reg;
    logic   [NUM_VERTS-1:0]  s0_neg_reg;
    coord_t [NUM_VERTS-1:0]  s0_bx_reg;
    mag_t   [NUM_VERTS-1:0]  s0_amag_reg;
    mag_t   [NUM_VERTS-1:0]  s0_bmag_reg;
    mag_t   [NUM_VERTS-1:0]  s0_cmag_reg;

    logic   [NUM_VERTS-1:0]  s0_active_next;
    logic   [NUM_VERTS-1:0]  s0_neg_next;
    coord_t [NUM_VERTS-1:0]  s0_bx_next;
    mag_t   [NUM_VERTS-1:0]  s0_amag_next;
    mag_t   [NUM_VERTS-1:0]  s0_bmag_next;
    mag_t   [NUM_VERTS-1:0]  s0_cmag_next;

    logic                    s1_valid_reg;
    coord_t                  s1_px_reg;
    lane_t  [NUM_VERTS-1:0]  s1_lanes_reg;
    lane_t  [NUM_VERTS-1:0]  s1_lanes_next;

    genvar e;
    generate
        for (e = 0; e < NUM_VERTS; e++) begin : g_edge
            localparam int J = (e + 1) % NUM_VERTS;
            coord_t bx, by, ex, ey;
            diff_t  a, b, c;
            assign bx = vertex[2*e];
            assign by = vertex[2*e+1];
            assign ex = vertex[2*J];
            assign ey = vertex[2*J+1];
            assign a  = ext_diff(in_point.point_y) - ext_diff(by);
            assign b  = ext_diff(ex) - ext_diff(bx);
            assign c  = ext_diff(ey) - ext_diff(by);
            assign s0_active_next[e] = (by != ey)
                && !(in_point.point_y < by && in_point.point_y < ey)
                && !(in_point.point_y > by && in_point.point_y > ey);
            assign s0_neg_next[e] = (a[COORD_WIDTH] ^ b[COORD_WIDTH] ^ c[COORD_WIDTH])
                && (a != '0) && (b != '0);
            assign s0_bx_next[e]   = bx;
            assign s0_amag_next[e] = mag_of(a);
            assign s0_bmag_next[e] = mag_of(b);
            assign s0_cmag_next[e] = mag_of(c);

            always_comb begin
                s1_lanes_next[e].active = s0_active_reg[e];
                s1_lanes_next[e].neg    = s0_neg_reg[e];
                s1_lanes_next[e].bx     = s0_bx_reg[e];
                s1_lanes_next[e].cmag   = s0_cmag_reg[e];
                s1_lanes_next[e].acc    = prod_t'(s0_amag_reg[e]) * prod_t'(s0_bmag_reg[e]);
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_px_reg     <= in_point.point_x;
            s0_active_reg <= s0_active_next;
            s0_neg_reg    <= s0_neg_next;
            s0_bx_reg     <= s0_bx_next;
            s0_amag_reg   <= s0_amag_next;
            s0_bmag_reg   <= s0_bmag_next;
            s0_cmag_reg   <= s0_cmag_next;
            s1_px_reg     <= s0_px_reg;
            s1_lanes_reg  <= s1_lanes_next;
        end
    end

    assign out_valid = s1_valid_reg;
    assign out_px    = s1_px_reg;
    assign out_lanes = s1_lanes_reg;

endmodule

>>> design/pip_div_cell.sv
// one restoring division cell: one quotient bit for every edge lane
`timescale 1ns / 1ps

module pip_div_cell
    import pip_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  coord_t                  in_px,
    input  lane_t [NUM_VERTS-1:0]   in_lanes,
    output logic                    out_valid,
    output coord_t                  out_px,
    output lane_t [NUM_VERTS-1:0]   out_lanes
);

    logic                   valid_reg;
    coord_t                 px_reg;
    lane_t [NUM_VERTS-1:0]  lanes_reg;
    lane_t [NUM_VERTS-1:0]  lanes_next;

    always_comb begin
        logic [COORD_WIDTH:0] trial;
        logic [COORD_WIDTH:0] rem;
        logic                 ge;
        for (int i = 0; i < NUM_VERTS; i++) begin
            trial = {in_lanes[i].acc[PROD_WIDTH-1:COORD_WIDTH], in_lanes[i].acc[COORD_WIDTH-1]};
            ge    = trial >= {1'b0, in_lanes[i].cmag};
            rem   = ge ? trial - {1'b0, in_lanes[i].cmag} : trial;
            lanes_next[i]     = in_lanes[i];
            lanes_next[i].acc = {rem[COORD_WIDTH-1:0], in_lanes[i].acc[COORD_WIDTH-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg    <= in_px;
            lanes_reg <= lanes_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_px    = px_reg;
    assign out_lanes = lanes_reg;

endmodule

>>> design/pip_crossing_count.sv
// crossing positions, right-of-point and repeat checks, count and output register
`timescale 1ns / 1ps

module pip_crossing_count
    import pip_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  coord_t                  in_px,
    input  lane_t [NUM_VERTS-1:0]   in_lanes,
    output logic                    out_valid,
    output result_t                 out_result
);

    logic                                   f1_valid_reg;
    coord_t                                 f1_px_reg;
    logic [NUM_VERTS-1:0]                   f1_active_reg;
    cx_t  [NUM_VERTS-1:0]                   f1_cx_reg;
    cx_t  [NUM_VERTS-1:0]                   f1_cx_next;

    logic                                   f2_valid_reg;
    logic [NUM_VERTS-1:0]                   f2_cand_reg;
    logic [NUM_VERTS-1:0]                   f2_cand_next;
    logic [NUM_VERTS-1:0][NUM_VERTS-1:0]    f2_eq_reg;
    logic [NUM_VERTS-1:0][NUM_VERTS-1:0]    f2_eq_next;

    logic                                   out_valid_reg;
    result_t                                result_reg;
    result_t                                result_next;

    always_comb begin
        cx_t q_ext;
        for (int i = 0; i < NUM_VERTS; i++) begin
            q_ext = {2'b00, in_lanes[i].acc[COORD_WIDTH-1:0]};
            f1_cx_next[i] = in_lanes[i].neg ? ext_cx(in_lanes[i].bx) - q_ext
                                            : ext_cx(in_lanes[i].bx) + q_ext;
        end
    end

    always_comb begin
        f2_eq_next = '0;
        for (int i = 0; i < NUM_VERTS; i++) begin
            f2_cand_next[i] = f1_active_reg[i] && (f1_cx_reg[i] > ext_cx(f1_px_reg));
            for (int j = 0; j < NUM_VERTS; j++) begin
                if (j > i) begin
                    f2_eq_next[i][j] = f1_cx_reg[i] == f1_cx_reg[j];
                end
            end
        end
    end

    // a crossing only repeats against the last one counted
    always_comb begin
        cnt_t                      cnt;
        logic                      last_valid;
        logic [EDGE_IDX_WIDTH-1:0] last_idx;
        cnt        = '0;
        last_valid = 1'b0;
        last_idx   = '0;
        for (int i = 0; i < NUM_VERTS; i++) begin
            if (f2_cand_reg[i] && (!last_valid || !f2_eq_reg[last_idx][i])) begin
                cnt        = cnt + 1'b1;
                last_idx   = EDGE_IDX_WIDTH'(i);
                last_valid = 1'b1;
            end
        end
        result_next.crossings  = cnt;
        result_next.inside_res = cnt[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg  <= in_valid;
            f2_valid_reg  <= f1_valid_reg;
            out_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_px_reg <= in_px;
            for (int i = 0; i < NUM_VERTS; i++) begin
                f1_active_reg[i] <= in_lanes[i].active;
            end
            f1_cx_reg   <= f1_cx_next;
            f2_cand_reg <= f2_cand_next;
            f2_eq_reg   <= f2_eq_next;
            result_reg  <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule

>>> test/tb_top.sv
// self-checking testbench for point_in_quadrilateral: directed and random points
`timescale 1ns / 1ps

module tb_top;
    import pip_pkg::*;

    localparam int     CLK_HALF     = 5;
    localparam int     RESET_CYCLES = 10;
    localparam int     IDLE_PCT     = 13;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     PIPE_CYCLES  = COORD_WIDTH + 5;
    localparam int     PHASES       = 13;
    localparam int     PHASE_POINTS = 85;
    localparam int     MAX_REPORTS  = 10;
    localparam longint COORD_MIN    = -(longint'(1) <<< (COORD_WIDTH - 1));
    localparam longint COORD_MAX    = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;

    typedef enum logic [REG_IDX_WIDTH-1:0] {
        REG_V0_X, REG_V0_Y, REG_V1_X, REG_V1_Y, REG_V2_X, REG_V2_Y, REG_V3_X, REG_V3_Y
    } vertex_reg_e;

    typedef enum logic [1:0] {RX_JITTER, RX_STEADY, RX_HOLD} rx_mode_e;

    typedef enum logic [2:0] {
        SHAPE_WIDE, SHAPE_SMALL, SHAPE_RECT, SHAPE_SHARED_Y, SHAPE_EXTREME
    } quad_shape_e;

    class crossing_board;
        coord_t  vert [NUM_REGS];
        result_t due_q [$];
        int      n_points;
        int      n_bad;

        function new();
            foreach (vert[i]) vert[i] = '0;
            n_points = 0;
            n_bad    = 0;
        endfunction

        function void set_vertex(vertex_reg_e idx, coord_t val);
            vert[idx] = val;
        endfunction

        function void flag(string msg);
            n_bad++;
            if (n_bad <= MAX_REPORTS) begin
                $display("mismatch at %0t: %s", $realtime, msg);
            end
        endfunction

        // ray toward +x, a crossing counts only right of the point and not equal to the last one
        function result_t crossing_result(point_t p);
            longint  px, py, bx, by, ex, ey, cx, last_x;
            bit      last_ok;
            int      cnt;
            int      nxt;
            result_t r;
            px      = p.point_x;
            py      = p.point_y;
            last_ok = 1'b0;
            last_x  = 0;
            cnt     = 0;
            for (int e = 0; e < NUM_VERTS; e++) begin
                nxt = (e + 1) % NUM_VERTS;
                bx  = vert[2 * e];
                by  = vert[2 * e + 1];
                ex  = vert[2 * nxt];
                ey  = vert[2 * nxt + 1];
                if (by == ey) continue;
                if (py < ((by < ey) ? by : ey) || py > ((by < ey) ? ey : by)) continue;
                cx = (py - by) * (ex - bx) / (ey - by) + bx;
                if (cx > px && (!last_ok || cx != last_x)) begin
                    cnt++;
                    last_x  = cx;
                    last_ok = 1'b1;
                end
            end
            r.inside_res = cnt[0];
            r.crossings  = cnt[CNT_WIDTH-1:0];
            return r;
        endfunction

        function void note_point(point_t p);
            due_q.insert(due_q.size(), crossing_result(p));
            n_points++;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_q.size() == 0) begin
                flag($sformatf("result beat with nothing expected: inside_res=%0b crossings=%0d",
                               got.inside_res, got.crossings));
                return;
            end
            want = due_q[0];
            due_q.delete(0);
            if (got.inside_res !== want.inside_res || got.crossings !== want.crossings) begin
                flag($sformatf("inside_res exp %0b got %0b, crossings exp %0d got %0d",
                               want.inside_res, got.inside_res, want.crossings, got.crossings));
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    point_t                   s_data    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    result_t                  m_data;
    logic                     cfg_we    = 1'b0;
    logic [REG_IDX_WIDTH-1:0] cfg_index = '0;
    coord_t                   cfg_wdata = '0;

    rx_mode_e      rx_mode         = RX_JITTER;
    bit            tx_steady       = 1'b0;
    int            settings_loaded = 0;
    coord_t        quad [NUM_REGS];
    crossing_board board;

    always #CLK_HALF aclk = ~aclk;

    point_in_quadrilateral i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_data);
        end
    end

    initial begin : receiver
        int held;
        held = 0;
        forever begin
            @(posedge aclk);
            case (rx_mode)
                RX_HOLD: begin
                    m_ready <= (held >= HOLD_CYCLES);
                    if (held < HOLD_CYCLES) held++;
                end
                RX_STEADY: begin
                    m_ready <= 1'b1;
                    held = 0;
                end
                default: begin
                    m_ready <= ($urandom_range(99) >= IDLE_PCT);
                    held = 0;
                end
            endcase
        end
    end

    initial begin : watchdog
        #1_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic longint pick(input longint lo, input longint hi);
        longint a, b;
        a = (lo < COORD_MIN) ? COORD_MIN : lo;
        b = (hi > COORD_MAX) ? COORD_MAX : hi;
        if (b <= a) return a;
        return a + longint'($urandom_range(32'(b - a)));
    endfunction

    function automatic longint corner_coord();
        case ($urandom_range(4))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    task automatic send_xy(input longint x, input longint y);
        point_t p;
        p.point_x = coord_t'(x);
        p.point_y = coord_t'(y);
        if (!tx_steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_point(p);
    endtask

    task automatic wait_results_in();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
    endtask

    task automatic load_quad(input longint x0, y0, x1, y1, x2, y2, x3, y3);
        longint v [NUM_REGS];
        v = '{x0, y0, x1, y1, x2, y2, x3, y3};
        wait_results_in();
        for (int i = 0; i < NUM_REGS; i++) begin
            quad[i] = coord_t'(v[i]);
            cfg_we    <= 1'b1;
            cfg_index <= vertex_reg_e'(i);
            cfg_wdata <= quad[i];
            @(posedge aclk);
            board.set_vertex(vertex_reg_e'(i), quad[i]);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
        settings_loaded++;
    endtask

    task automatic random_quad(input quad_shape_e shape);
        longint c [NUM_REGS];
        longint mx, my, r, xa, xb, ya, yb;
        mx = pick(COORD_MIN, COORD_MAX);
        my = pick(COORD_MIN, COORD_MAX);
        r  = $urandom_range(5000) + 1;
        xa = pick(mx - r, mx + r);
        xb = pick(mx - r, mx + r);
        ya = pick(my - r, my + r);
        yb = pick(my - r, my + r);
        for (int i = 0; i < NUM_VERTS; i++) begin
            case (shape)
                SHAPE_WIDE: begin
                    c[2 * i]     = pick(COORD_MIN, COORD_MAX);
                    c[2 * i + 1] = pick(COORD_MIN, COORD_MAX);
                end
                SHAPE_SMALL: begin
                    c[2 * i]     = pick(mx - r, mx + r);
                    c[2 * i + 1] = pick(my - r, my + r);
                end
                SHAPE_RECT: begin
                    c[2 * i]     = (i == 1 || i == 2) ? xb : xa;
                    c[2 * i + 1] = (i >= 2) ? yb : ya;
                end
                SHAPE_SHARED_Y: begin
                    c[2 * i]     = pick(mx - r, mx + r);
                    c[2 * i + 1] = $urandom_range(1) ? ya : yb;
                    // repeated vertex now and then
                    if (i > 0 && $urandom_range(3) == 0) begin
                        c[2 * i]     = c[2 * i - 2];
                        c[2 * i + 1] = c[2 * i - 1];
                    end
                end
                default: begin
                    c[2 * i]     = corner_coord();
                    c[2 * i + 1] = corner_coord();
                end
            endcase
        end
        load_quad(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endtask

    task automatic random_point();
        longint lo_x, hi_x, lo_y, hi_y, mx, my;
        int     sel;
        lo_x = quad[0];
        hi_x = quad[0];
        lo_y = quad[1];
        hi_y = quad[1];
        for (int i = 1; i < NUM_VERTS; i++) begin
            if (quad[2 * i] < lo_x) lo_x = quad[2 * i];
            if (quad[2 * i] > hi_x) hi_x = quad[2 * i];
            if (quad[2 * i + 1] < lo_y) lo_y = quad[2 * i + 1];
            if (quad[2 * i + 1] > hi_y) hi_y = quad[2 * i + 1];
        end
        mx  = (hi_x - lo_x) / 4 + 4;
        my  = (hi_y - lo_y) / 4 + 4;
        sel = $urandom_range(99);
        if (sel < 20) begin
            send_xy(pick(COORD_MIN, COORD_MAX), pick(COORD_MIN, COORD_MAX));
        end else if (sel < 45) begin
            send_xy(pick(lo_x - mx, hi_x + mx), quad[2 * $urandom_range(NUM_VERTS - 1) + 1]);
        end else if (sel < 55) begin
            send_xy(quad[2 * $urandom_range(NUM_VERTS - 1)], pick(lo_y - my, hi_y + my));
        end else begin
            send_xy(pick(lo_x - mx, hi_x + mx), pick(lo_y - my, hi_y + my));
        end
    endtask

    initial begin : stimulus
        board = new();
        foreach (quad[i]) quad[i] = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all vertices at zero after reset
        send_xy(0, 0);
        send_xy(COORD_MIN, COORD_MIN);
        send_xy(COORD_MAX, COORD_MAX);

        load_quad(-1000, -1000, 1000, -1000, 1000, 1000, -1000, 1000);
        send_xy(0, 0);
        send_xy(2000, 0);
        send_xy(-2000, 0);
        send_xy(-1000, 0);
        send_xy(-2000, 1000);
        send_xy(0, -1000);
        send_xy(COORD_MAX, 0);
        send_xy(COORD_MIN, 500);

        // diamond, corners shared by two sides
        load_quad(0, -1000, 1000, 0, 0, 1000, -1000, 0);
        send_xy(-2000, 0);
        send_xy(0, 0);
        send_xy(-2000, 1000);
        send_xy(500, 500);
        send_xy(-2000, -1000);

        // self-crossing quad, same crossing x comes back after a different one
        load_quad(0, -100, 0, 100, 100, -100, -100, 100);
        send_xy(-10, 0);
        send_xy(-200, 0);
        send_xy(20, 50);

        load_quad(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX,
                  COORD_MIN, COORD_MAX);
        send_xy(0, 0);
        send_xy(COORD_MIN, 0);
        send_xy(COORD_MAX - 1, COORD_MAX);
        send_xy(COORD_MIN, COORD_MIN);

        for (int ph = 0; ph < PHASES; ph++) begin
            random_quad(quad_shape_e'(ph % 5));
            rx_mode   <= (ph == 3) ? RX_HOLD : (ph == 7) ? RX_STEADY : RX_JITTER;
            tx_steady = (ph == 3 || ph == 7);
            for (int n = 0; n < PHASE_POINTS; n++) begin
                if (ph == 5 && n == PHASE_POINTS / 2) wait_results_in();
                random_point();
            end
        end

        wait_results_in();
        repeat (PIPE_CYCLES + 10) @(posedge aclk);
        $display("covered %0d points over %0d vertex settings %s",
                 board.n_points, settings_loaded,
                 "(degenerate, extreme, shared corner, random)");
        $display("with a %0d-cycle receiver hold-off and a mid-stream drain; %0d mismatches",
                 HOLD_CYCLES, board.n_bad);
        if (board.n_bad == 0 && board.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
